// File: rtl/core/assert_macros.svh
// assertion macros shared by the equalizer rtl
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// File: rtl/core/fbeq_pkg.sv
// shared types and constants for the four band stereo biquad equalizer
// used by fbeq_ctrl, fbeq_dp and the top level
package fbeq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_WORDS  = 7;
	localparam int COEF_BITS   = 21;
	localparam int COEF_FRAC   = 17;
	localparam int GAIN_BITS   = 24;
	localparam int GAIN_FRAC   = 20;
	localparam int ENABLE_BITS = 4;
	localparam int CFG_BITS    = 63;
	localparam int CTRL_BITS   = 29;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_SLOTS   = 21;
	localparam int TERMS       = 5;

	localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 3'd7;

	// history taps of one band and channel
	localparam logic [1:0] TAP_X1 = 2'd0;
	localparam logic [1:0] TAP_X2 = 2'd1;
	localparam logic [1:0] TAP_Y1 = 2'd2;
	localparam logic [1:0] TAP_Y2 = 2'd3;

	// multiplier operand select
	localparam logic [2:0] TERM_B0   = 3'd0;
	localparam logic [2:0] TERM_B1   = 3'd1;
	localparam logic [2:0] TERM_B2   = 3'd2;
	localparam logic [2:0] TERM_A1   = 3'd3;
	localparam logic [2:0] TERM_A2   = 3'd4;
	localparam logic [2:0] TERM_GAIN = 3'd5;

	typedef logic [COEF_WORDS-1:0][CFG_BITS-1:0] coef_bank_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]   gain;
		logic                   bypass;
		logic [ENABLE_BITS-1:0] enable;
	} ctrl_reg_t;

	localparam coef_bank_t COEF_RST = {
		63'd0, 63'd131072, 63'd0, 63'd274877906944,
		63'd0, 63'd576460752303423488, 63'd131072
	};
	localparam ctrl_reg_t CTRL_RST = 29'd33554447;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic                          clipped;
	} out_t;

	typedef struct packed {
		logic       ch;
		logic       ld_frame;
		logic       ld_right;
		logic       rd_en;
		logic [1:0] rd_tap;
		logic       wr_en;
		logic [1:0] wr_tap;
		logic       mul_en;
		logic [2:0] term;
		logic       acc_en;
		logic       acc_clr;
		logic       rnd_band;
		logic       upd_val;
		logic       rnd_gain;
		logic       out_load;
	} cmd_t;

endpackage

// File: rtl/core/fbeq_ctrl.sv
// sequencer for the equalizer: walks channels, bands and mac steps
// depends on fbeq_pkg; drives fbeq_dp through cmd_t
module fbeq_ctrl #(
	parameter int BANDS = 4,
	parameter int BIW   = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  logic [fbeq_pkg::ENABLE_BITS-1:0] enable,
	input  logic                             bypass,
	output fbeq_pkg::cmd_t                   cmd,
	output logic [BIW-1:0]                   band
);
	import fbeq_pkg::*;

	localparam int BW = $clog2(BANDS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BAND = 3'd1;
	localparam logic [2:0] S_MAC  = 3'd2;
	localparam logic [2:0] S_GAIN = 3'd3;
	localparam logic [2:0] S_GRND = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [2:0]    step_q, step_d;
	logic [BW-1:0] band_q, band_d;
	logic          ch_q, ch_d;
	logic          out_valid_q;
	logic          band_en;

	always_comb begin
		band_en = 1'b0;
		for (int i = 0; i < ENABLE_BITS; i++) begin
			if (int'(band_q) == i) band_en = enable[i];
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		band_d  = band_q;
		ch_d    = ch_q;
		cmd     = '0;
		cmd.ch  = ch_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_frame = 1'b1;
					band_d       = '0;
					ch_d         = 1'b0;
					state_d      = bypass ? S_DONE : S_BAND;
				end
			end
			S_BAND: begin
				if (band_q == BW'(BANDS)) begin
					state_d = S_GAIN;
				end else if (band_en) begin
					step_d  = '0;
					state_d = S_MAC;
				end else begin
					band_d = band_q + 1'b1;
				end
			end
			S_MAC: begin
				step_d = step_q + 3'd1;
				case (step_q)
					3'd0: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_tap = TAP_X1;
						cmd.mul_en = 1'b1;
						cmd.term   = TERM_B0;
					end
					3'd1: begin
						cmd.rd_en   = 1'b1;
						cmd.rd_tap  = TAP_X2;
						cmd.mul_en  = 1'b1;
						cmd.term    = TERM_B1;
						cmd.acc_en  = 1'b1;
						cmd.acc_clr = 1'b1;
					end
					3'd2: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_tap = TAP_Y1;
						cmd.mul_en = 1'b1;
						cmd.term   = TERM_B2;
						cmd.acc_en = 1'b1;
						cmd.wr_en  = 1'b1;
						cmd.wr_tap = TAP_X2;
					end
					3'd3: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_tap = TAP_Y2;
						cmd.mul_en = 1'b1;
						cmd.term   = TERM_A1;
						cmd.acc_en = 1'b1;
						cmd.wr_en  = 1'b1;
						cmd.wr_tap = TAP_X1;
					end
					3'd4: begin
						cmd.mul_en = 1'b1;
						cmd.term   = TERM_A2;
						cmd.acc_en = 1'b1;
						cmd.wr_en  = 1'b1;
						cmd.wr_tap = TAP_Y2;
					end
					3'd5: begin
						cmd.acc_en = 1'b1;
					end
					3'd6: begin
						cmd.rnd_band = 1'b1;
					end
					default: begin
						cmd.wr_en   = 1'b1;
						cmd.wr_tap  = TAP_Y1;
						cmd.upd_val = 1'b1;
						band_d      = band_q + 1'b1;
						state_d     = S_BAND;
					end
				endcase
			end
			S_GAIN: begin
				cmd.mul_en = 1'b1;
				cmd.term   = TERM_GAIN;
				state_d    = S_GRND;
			end
			S_GRND: begin
				cmd.rnd_gain = 1'b1;
				if (!ch_q) begin
					cmd.ld_right = 1'b1;
					ch_d         = 1'b1;
					band_d       = '0;
					state_d      = S_BAND;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			band_q      <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			band_q  <= band_d;
			ch_q    <= ch_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign band      = band_q[BIW-1:0];

endmodule

// File: rtl/core/fbeq_dp.sv
// equalizer datapath: tap memory, shared multiplier, accumulator,
// rounding and saturation, result register; depends on fbeq_pkg
module fbeq_dp #(
	parameter int BANDS      = 4,
	parameter int STATE_BITS = 28,
	parameter int BIW        = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fbeq_pkg::cmd_t                 cmd,
	input  logic [BIW-1:0]                 band,
	input  fbeq_pkg::in_t                  in_data,
	input  fbeq_pkg::coef_bank_t           coef,
	input  logic [fbeq_pkg::GAIN_BITS-1:0] gain,
	output fbeq_pkg::out_t                 out_data
);
	import fbeq_pkg::*;

	localparam int VAL_W = (SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS;
	localparam int MA_W  = GAIN_BITS + 1;
	localparam int PW    = VAL_W + MA_W;
	localparam int ACC_W = PW + 1;
	localparam int DEPTH = 8 * BANDS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic signed [ACC_W-1:0] BAND_RND = ACC_W'(2 ** (COEF_FRAC - 1));
	localparam logic signed [ACC_W-1:0] GAIN_RND = ACC_W'(2 ** (GAIN_FRAC - 1));
	localparam logic signed [STATE_BITS-1:0] ST_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [STATE_BITS-1:0] ST_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SM_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SM_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [COEF_BITS-1:0] coef_slot [NUM_SLOTS];

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
		assign coef_slot[g] = coef[g / 3][COEF_BITS * (g % 3) +: COEF_BITS];
	end

	logic [VAL_W-1:0]              mem [DEPTH];
	logic [DEPTH-1:0]              vld_q;
	logic [VAL_W-1:0]              rd_raw_q;
	logic                          rd_vld_q;
	logic signed [VAL_W-1:0]       rd_val;
	logic [AW-3:0]                 row;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic [VAL_W-1:0]              wr_data;

	logic signed [VAL_W-1:0]       val_q, x1_q, y1_q;
	logic signed [SAMPLE_BITS-1:0] right_q, res_l_q, res_r_q;
	logic                          clip_q;
	logic signed [STATE_BITS-1:0]  y_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	out_t                          out_q;

	logic [5:0]                    slot;
	logic signed [COEF_BITS-1:0]   coef_sel;
	logic signed [MA_W-1:0]        mul_a;
	logic signed [VAL_W-1:0]       mul_b;

	logic signed [ACC_W-1:0]       bsh, gsh;
	logic [ACC_W-STATE_BITS:0]     btop;
	logic [ACC_W-SAMPLE_BITS:0]    gtop;
	logic                          bovf, govf;
	logic signed [STATE_BITS-1:0]  band_sat;
	logic signed [SAMPLE_BITS-1:0] gain_sat;

	// tap addressing: row per channel and band, four taps per row
	assign row     = (AW-2)'(cmd.ch ? BANDS : 0) + (AW-2)'(band);
	assign rd_addr = {row, cmd.rd_tap};
	assign wr_addr = {row, cmd.wr_tap};
	assign rd_val  = rd_vld_q ? $signed(rd_raw_q) : '0;

	always_comb begin
		case (cmd.wr_tap)
			TAP_X2:  wr_data = x1_q;
			TAP_X1:  wr_data = val_q;
			TAP_Y2:  wr_data = y1_q;
			default: wr_data = VAL_W'(y_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_en) vld_q[wr_addr] <= 1'b1;
			if (cmd.rd_en) rd_vld_q <= vld_q[rd_addr];
		end
	end

	// multiplier operands
	assign slot     = 6'(band) * 6'(TERMS) + 6'(cmd.term);
	assign coef_sel = (slot < 6'(NUM_SLOTS)) ? coef_slot[slot[4:0]] : '0;

	always_comb begin
		case (cmd.term) inside
			TERM_GAIN:        mul_a = {1'b0, gain};
			TERM_A1, TERM_A2: mul_a = -MA_W'(coef_sel);
			default:          mul_a = MA_W'(coef_sel);
		endcase
		mul_b = (cmd.term == TERM_B0 || cmd.term == TERM_GAIN) ? val_q : rd_val;
	end

	// band rounding and saturation
	assign bsh      = (acc_q + BAND_RND) >>> COEF_FRAC;
	assign btop     = bsh[ACC_W-1:STATE_BITS-1];
	assign bovf     = !((&btop) || !(|btop));
	assign band_sat = bovf ? (bsh[ACC_W-1] ? ST_MIN : ST_MAX) : bsh[STATE_BITS-1:0];

	// output gain rounding and saturation
	assign gsh      = ($signed({prod_q[PW-1], prod_q}) + GAIN_RND) >>> GAIN_FRAC;
	assign gtop     = gsh[ACC_W-1:SAMPLE_BITS-1];
	assign govf     = !((&gtop) || !(|gtop));
	assign gain_sat = govf ? (gsh[ACC_W-1] ? SM_MIN : SM_MAX) : gsh[SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.ld_frame) begin
			right_q <= in_data.right_sample;
			res_l_q <= in_data.left_sample;
			res_r_q <= in_data.right_sample;
			clip_q  <= 1'b0;
			val_q   <= VAL_W'(in_data.left_sample);
		end
		if (cmd.ld_right) val_q <= VAL_W'(right_q);
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
			if (cmd.term == TERM_B1) x1_q <= rd_val;
			if (cmd.term == TERM_A1) y1_q <= rd_val;
		end
		if (cmd.acc_en) begin
			acc_q <= (cmd.acc_clr ? '0 : acc_q) + $signed({prod_q[PW-1], prod_q});
		end
		if (cmd.rnd_band) begin
			y_q <= band_sat;
			if (bovf) clip_q <= 1'b1;
		end
		if (cmd.upd_val) val_q <= VAL_W'(y_q);
		if (cmd.rnd_gain) begin
			if (cmd.ch) begin
				res_r_q <= gain_sat;
			end else begin
				res_l_q <= gain_sat;
			end
			if (govf) clip_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_q.left_out  <= res_l_q;
			out_q.right_out <= res_r_q;
			out_q.clipped   <= clip_q;
		end
	end

	assign out_data = out_q;

endmodule

// File: rtl/core/four_band_stereo_biquad_eq_unit.sv
// top level of the four band stereo biquad equalizer: config registers,
// sequencer and datapath; depends on fbeq_pkg, fbeq_ctrl, fbeq_dp
//
// in channel: in_valid/in_ready carry one stereo frame per beat (in_data).
// out channel: out_valid/out_ready carry one filtered frame per beat,
// with a clip flag set if any band or the output gain saturated.
// config: cfg_we writes cfg_wdata to register cfg_index;
// indexes 0..6 are the packed coefficient words, 7 is the control word.
// write config only while no frame is in flight.
// each channel runs through the enabled bands on one shared multiplier;
// a band runs five products, an accumulate, a round and a tap update.
// with bypass set the bands and the gain are skipped and the input frame
// goes to the output register as it came in. the frame's result is loaded
// into the output register when the sequencer reaches its done state.
// a stalled receiver holds the finished frame in the output register while
// the next frame is taken and filtered; that frame then waits until the
// register is free.
// reset: tap history reads as zero (per-entry valid bits, no clearing
// pass), coefficients load unity b0 per band, all bands on, gain 1.0.
`include "assert_macros.svh"

module four_band_stereo_biquad_eq_unit #(
	parameter int BANDS      = 4,
	parameter int STATE_BITS = 28
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fbeq_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fbeq_pkg::out_t                 out_data,
	input  logic                           cfg_we,
	input  logic [fbeq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbeq_pkg::CFG_BITS-1:0]  cfg_wdata
);
	import fbeq_pkg::*;

	localparam int BIW = (BANDS > 1) ? $clog2(BANDS) : 1;

	coef_bank_t     coef_q;
	ctrl_reg_t      ctrl_q;
	cmd_t           cmd;
	logic [BIW-1:0] band;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RST;
			ctrl_q <= CTRL_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_CONTROL) begin
				ctrl_q <= cfg_wdata[CTRL_BITS-1:0];
			end else begin
				coef_q[cfg_index] <= cfg_wdata;
			end
		end
	end

	fbeq_ctrl #(
		.BANDS (BANDS),
		.BIW   (BIW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.enable    (ctrl_q.enable),
		.bypass    (ctrl_q.bypass),
		.cmd       (cmd),
		.band      (band)
	);

	fbeq_dp #(
		.BANDS      (BANDS),
		.STATE_BITS (STATE_BITS),
		.BIW        (BIW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.band     (band),
		.in_data  (in_data),
		.coef     (coef_q),
		.gain     (ctrl_q.gain),
		.out_data (out_data)
	);

	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`ASSERT_CLK(a_no_result_overwrite, clk, arst_n, cmd.out_load |-> !out_valid || out_ready)
	`ASSERT_NEVER(a_tap_rw_clash, clk, arst_n, cmd.wr_en && cmd.rd_en && cmd.wr_tap == cmd.rd_tap)
	`ASSERT_CLK(a_phase_onehot, clk, arst_n,
		$onehot0({cmd.ld_frame, cmd.rnd_band, cmd.rnd_gain, cmd.out_load}))

endmodule
